### rtl/wca_pkg.sv
// shared types, widths and register codes of the weighted channel argmax
`default_nettype none
package wca_pkg;

    // fixed field widths
    localparam int NUM_CH     = 4;
    localparam int ACT_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int SKIP_W     = NUM_CH;
    localparam int PROD_W     = ACT_W + GAIN_W + 1;
    localparam int SCORE_W    = 34;
    localparam int IDX_W      = 10;
    localparam int INDEX_SPAN = 1 << IDX_W;

    // stream and config port widths
    localparam int S_TDATA_W  = NUM_CH * ACT_W;
    localparam int M_TDATA_W  = ((IDX_W + SCORE_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - IDX_W - SCORE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int DEF_LANES          = 4;
    localparam int DEF_MAX_CATEGORIES = 1024;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_CH0     = 3'd0,
        REG_GAIN_CH1     = 3'd1,
        REG_GAIN_CH2     = 3'd2,
        REG_GAIN_CH3     = 3'd3,
        REG_CHANNEL_SKIP = 3'd4
    } wca_reg_t;

endpackage
`default_nettype wire

### rtl/wca_lane.sv
// one lane: weighted product of a channel activation, registered
`default_nettype none
module wca_lane (
    input  wire logic                           aclk,
    input  wire logic                           load,
    input  wire logic [wca_pkg::ACT_W-1:0]      act,
    input  wire logic [wca_pkg::GAIN_W-1:0]     gain,
    input  wire logic                           skip,
    output logic signed [wca_pkg::PROD_W-1:0]   prod
);
    import wca_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // signed activation times unsigned gain, zero when the channel is skipped
    always_comb begin
        if (skip) begin
            prod_next = '0;
        end else begin
            prod_next = $signed(act) * $signed({1'b0, gain});
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

### rtl/wca_merge.sv
// merge stage: lane sum, running best compare, search state and result register
`default_nettype none
module wca_merge #(
    parameter int ACT_LANES      = wca_pkg::NUM_CH,
    parameter int MAX_CATEGORIES = wca_pkg::DEF_MAX_CATEGORIES
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // request entering the lanes
    input  wire logic                               in_valid,
    input  wire logic                               in_last,
    output logic                                    in_ready,
    // lane products of the request held in the lanes
    input  wire logic signed [wca_pkg::PROD_W-1:0]  prod [ACT_LANES],
    // result
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [wca_pkg::IDX_W-1:0]               out_index,
    output logic signed [wca_pkg::SCORE_W-1:0]      out_score,
    output logic                                    out_overflow
);
    import wca_pkg::*;

    localparam int CAT_LIMIT = (MAX_CATEGORIES > INDEX_SPAN) ? INDEX_SPAN : MAX_CATEGORIES;
    localparam int CNT_W     = $clog2(CAT_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CAT_LIMIT);

    // stage valid flags
    logic v1_reg, last1_reg;
    logic v2_reg, last2_reg;
    logic signed [SCORE_W-1:0] sum_reg;
    logic signed [SCORE_W-1:0] sum_next;

    // search state
    logic [CNT_W-1:0]          cnt_reg;
    logic [IDX_W-1:0]          lead_idx_reg;
    logic signed [SCORE_W-1:0] lead_score_reg;
    logic                      have_reg;
    logic                      ovf_reg;

    // result register
    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_index_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic                      out_overflow_reg;

    logic out_free, go3, ld2, ld1;
    logic in_range, take;
    logic [CNT_W-1:0]          cnt_next;
    logic [IDX_W-1:0]          lead_idx_next;
    logic signed [SCORE_W-1:0] lead_score_next;
    logic                      have_next;
    logic                      ovf_next;

    // flow control: only a last request needs room in the result register
    assign out_free = !out_valid_reg || out_ready;
    assign go3      = v2_reg && (!last2_reg || out_free);
    assign ld2      = !v2_reg || go3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // exact sum of the lane products
    always_comb begin
        sum_next = '0;
        for (int l = 0; l < ACT_LANES; l++) begin
            sum_next = sum_next + SCORE_W'(prod[l]);
        end
    end

    // compare against the running best, first category always taken
    always_comb begin
        in_range        = cnt_reg < CNT_LIMIT;
        take            = in_range && (!have_reg || (sum_reg > lead_score_reg));
        lead_score_next = take ? sum_reg : lead_score_reg;
        lead_idx_next   = take ? IDX_W'(cnt_reg) : lead_idx_reg;
        have_next       = have_reg || take;
        ovf_next        = ovf_reg || !in_range;
        cnt_next        = in_range ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg    <= in_valid;
                last1_reg <= in_last;
            end
            if (ld2) begin
                v2_reg    <= v1_reg;
                last2_reg <= last1_reg;
            end
        end
    end

    // summed score
    always_ff @(posedge aclk) begin
        if (ld2 && v1_reg) begin
            sum_reg <= sum_next;
        end
    end

    // search state, cleared after the last category
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            lead_idx_reg   <= '0;
            lead_score_reg <= '0;
            have_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
        end else if (go3) begin
            if (last2_reg) begin
                cnt_reg        <= '0;
                lead_idx_reg   <= '0;
                lead_score_reg <= '0;
                have_reg       <= 1'b0;
                ovf_reg        <= 1'b0;
            end else begin
                cnt_reg        <= cnt_next;
                lead_idx_reg   <= lead_idx_next;
                lead_score_reg <= lead_score_next;
                have_reg       <= have_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (go3 && last2_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go3 && last2_reg) begin
            out_index_reg    <= lead_idx_next;
            out_score_reg    <= lead_score_next;
            out_overflow_reg <= ovf_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign out_score    = out_score_reg;
    assign out_overflow = out_overflow_reg;
endmodule
`default_nettype wire

### rtl/weighted_channel_argmax.sv
// weighted channel argmax: gain registers, parallel product lanes and merge stage
// the last category's result passes the lane product, sum and result registers to m_tvalid
// throughput: one category per cycle, set by the lane multipliers feeding one sum and compare
// backpressure only stalls when a last category finds the result register still full
// reset (aresetn low, synchronous): gains return to 16384, skip mask to zero,
// search state and all valid flags are cleared
`default_nettype none
module weighted_channel_argmax #(
    parameter int LANES          = wca_pkg::DEF_LANES,
    parameter int MAX_CATEGORIES = wca_pkg::DEF_MAX_CATEGORIES
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // category stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // act_ch0 [15:0], act_ch1 [31:16], act_ch2 [47:32], act_ch3 [63:48]
    input  wire logic [wca_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                               s_tlast,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // best_index [9:0], top_score [43:10], zero [47:44]
    output logic [wca_pkg::M_TDATA_W-1:0]           m_tdata,
    // count_overflow [0]
    output logic                                    m_tuser,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wca_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wca_pkg::*;

    localparam int ACT_LANES = (LANES < NUM_CH) ? LANES : NUM_CH;

    logic [GAIN_W-1:0]        gain_reg [NUM_CH];
    logic [SKIP_W-1:0]        skip_reg;
    logic signed [PROD_W-1:0] prod [ACT_LANES];
    logic                     load;
    logic [IDX_W-1:0]         best_index;
    logic signed [SCORE_W-1:0] top_score;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CH; k++) begin
                gain_reg[k] <= GAIN_RESET;
            end
            skip_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index) inside
                REG_GAIN_CH0, REG_GAIN_CH1, REG_GAIN_CH2, REG_GAIN_CH3: begin
                    gain_reg[cfg_index[1:0]] <= cfg_data[GAIN_W-1:0];
                end
                REG_CHANNEL_SKIP: begin
                    skip_reg <= cfg_data[SKIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // lanes load on an accepted request
    assign load = s_tvalid && s_tready;

    for (genvar l = 0; l < ACT_LANES; l++) begin : g_lane
        wca_lane u_lane (
            .aclk (aclk),
            .load (load),
            .act  (s_tdata[l*ACT_W +: ACT_W]),
            .gain (gain_reg[l]),
            .skip (skip_reg[l]),
            .prod (prod[l])
        );
    end

    // sum, compare and result register
    wca_merge #(
        .ACT_LANES      (ACT_LANES),
        .MAX_CATEGORIES (MAX_CATEGORIES)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_last      (s_tlast),
        .in_ready     (s_tready),
        .prod         (prod),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_index    (best_index),
        .out_score    (top_score),
        .out_overflow (m_tuser)
    );

    // result packing
    assign m_tdata = {{M_PAD_W{1'b0}}, top_score, best_index};
endmodule
`default_nettype wire

### tb/tb_weighted_channel_argmax.sv
// self-checking testbench for the weighted channel argmax category search
`timescale 1ns / 1ps
`default_nettype none
module tb_weighted_channel_argmax;
    import wca_pkg::*;

    // run limits and pacing
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int LANE_CNT     = (DEF_LANES < NUM_CH) ? DEF_LANES : NUM_CH;
    localparam int CAT_LIMIT    = (DEF_MAX_CATEGORIES < INDEX_SPAN) ?
                                  DEF_MAX_CATEGORIES : INDEX_SPAN;

    // register indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'(REG_CHANNEL_SKIP) + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    // activation extremes, Q1.15
    localparam logic [ACT_W-1:0] ACT_MOST_NEG = 16'h8000;
    localparam logic [ACT_W-1:0] ACT_MOST_POS = 16'h7fff;
    localparam logic [ACT_W-1:0] ACT_MINUS_1  = 16'hffff;

    // one expected search result
    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        logic               ovf;
    } choice_t;

    // one row of the directed plan: a register write or a category
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [S_TDATA_W-1:0]  acts;
        logic                  last;
        bit                    typed;
        choice_t               want;
    } plan_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // shadow of the registers and of the running search
    logic [GAIN_W-1:0] gain_reg [NUM_CH];
    logic [SKIP_W-1:0] skip_reg;
    int unsigned       cat_count;
    logic [IDX_W-1:0]  lead_idx;
    longint            lead_score;
    bit                lead_valid;
    bit                ovf_seen;

    choice_t choice_q [$];
    choice_t no_choice;

    int src_gap_pct;
    int sink_stall_pct;
    int hold_left;
    int cycle_cnt;
    int n_errors;
    int n_results;
    int n_ovf_results;
    int n_cats_sent;
    int n_searches;
    int n_cfg;

    weighted_channel_argmax u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, choice_q.size());
            $display("tb_weighted_channel_argmax: FAIL");
            $finish;
        end
    end

    // result receiver: random stalls plus a long hold-off on demand
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // result checker: each accepted result against the oldest expectation
    always @(posedge aclk) begin
        choice_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tuser === 1'b1) n_ovf_results++;
            if (choice_q.size() == 0) begin
                $display("%0t: result with none expected: index %0d score %0d overflow %b",
                         $time, m_tdata[IDX_W-1:0], $signed(m_tdata[IDX_W +: SCORE_W]),
                         m_tuser);
                n_errors++;
            end else begin
                exp_c = choice_q.pop_front();
                if (m_tdata[IDX_W-1:0] !== exp_c.idx) begin
                    $display("%0t: best_index expected %0d actual %0d",
                             $time, exp_c.idx, m_tdata[IDX_W-1:0]);
                    n_errors++;
                end
                if (m_tdata[IDX_W +: SCORE_W] !== exp_c.score) begin
                    $display("%0t: top_score expected %0d actual %0d", $time,
                             $signed(exp_c.score), $signed(m_tdata[IDX_W +: SCORE_W]));
                    n_errors++;
                end
                if (m_tdata[M_TDATA_W-1:IDX_W+SCORE_W] !== '0) begin
                    $display("%0t: pad bits expected 0 actual %h",
                             $time, m_tdata[M_TDATA_W-1:IDX_W+SCORE_W]);
                    n_errors++;
                end
                if (m_tuser !== exp_c.ovf) begin
                    $display("%0t: count_overflow expected %b actual %b",
                             $time, exp_c.ovf, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // exact weighted sum over the enabled lanes
    function automatic longint weighted_sum(input logic [S_TDATA_W-1:0] acts);
        longint acc;
        int k;
        acc = 0;
        for (k = 0; k < LANE_CNT; k++) begin
            if (!skip_reg[k])
                acc += longint'($signed(acts[ACT_W*k +: ACT_W])) *
                       longint'({1'b0, gain_reg[k]});
        end
        return acc;
    endfunction

    // advance the search by one category; returns 1 when a result is due
    function automatic bit rank_category(input logic [S_TDATA_W-1:0] acts, input logic last,
                                         output choice_t res);
        longint score;
        score = weighted_sum(acts);
        res = no_choice;
        // categories past the limit only raise the overflow flag
        if (cat_count >= CAT_LIMIT) begin
            ovf_seen = 1'b1;
        end else begin
            if (!lead_valid || score > lead_score) begin
                lead_score = score;
                lead_idx   = cat_count[IDX_W-1:0];
                lead_valid = 1'b1;
            end
            cat_count++;
        end
        if (!last) return 1'b0;
        res.idx   = lead_idx;
        res.score = lead_score[SCORE_W-1:0];
        res.ovf   = ovf_seen;
        cat_count  = 0;
        lead_idx   = '0;
        lead_score = 0;
        lead_valid = 1'b0;
        ovf_seen   = 1'b0;
        return 1'b1;
    endfunction

    // offer one category request and record its expected result
    task automatic push_category(input logic [S_TDATA_W-1:0] acts, input logic last,
                                 input bit typed, input choice_t want);
        choice_t pred;
        bit      has;
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= acts;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        has = rank_category(acts, last, pred);
        n_cats_sent++;
        if (has) begin
            choice_q.push_back(typed ? want : pred);
            n_searches++;
        end
    endtask

    // register write request; the caller lowers cfg_valid after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_GAIN_CH3)
            gain_reg[idx[1:0]] = data;
        else if (idx == REG_CHANNEL_SKIP)
            skip_reg = data[SKIP_W-1:0];
        n_cfg++;
    endtask

    // stop offering, wait for every expected result, then let the pipe settle
    task automatic wait_idle(input int pause);
        s_tvalid <= 1'b0;
        while (choice_q.size() != 0) @(posedge aclk);
        repeat (pause) @(posedge aclk);
    endtask

    // new register setting, extremes favored
    task automatic set_random_config(input bit full_gain);
        int k;
        logic [GAIN_W-1:0] g;
        logic [SKIP_W-1:0] mask;
        wait_idle(DRAIN_CYCLES);
        for (k = 0; k < NUM_CH; k++) begin
            case ($urandom_range(0, 4))
                0: g = '0;
                1: g = '1;
                default: g = 16'($urandom);
            endcase
            if (full_gain) g = '1;
            write_reg(3'(REG_GAIN_CH0) + 3'(k), g);
        end
        case ($urandom_range(0, 3))
            0: mask = '0;
            1: mask = '1;
            default: mask = 4'($urandom);
        endcase
        if (full_gain) mask = '0;
        // upper data bits of the skip register are don't-care
        write_reg(REG_CHANNEL_SKIP, {12'($urandom), mask});
        write_reg(REG_SPARE_FIRST + 3'($urandom_range(0, REG_SPARE_LAST - REG_SPARE_FIRST)),
                  16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // next category: a repeat of the previous one, lane extremes, or random
    function automatic logic [S_TDATA_W-1:0] next_acts(input logic [S_TDATA_W-1:0] prev);
        logic [S_TDATA_W-1:0] a;
        int k;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) return prev;
        a = {$urandom, $urandom};
        if (pick < 32) begin
            for (k = 0; k < NUM_CH; k++) begin
                case ($urandom_range(0, 3))
                    0: a[ACT_W*k +: ACT_W] = ACT_MOST_NEG;
                    1: a[ACT_W*k +: ACT_W] = ACT_MOST_POS;
                    2: a[ACT_W*k +: ACT_W] = '0;
                    default: a[ACT_W*k +: ACT_W] = ACT_MINUS_1;
                endcase
            end
        end
        return a;
    endfunction

    // short searches of random length until n_items categories were sent
    task automatic run_searches(input int n_items);
        int done;
        int len;
        int i;
        logic [S_TDATA_W-1:0] acts;
        done = 0;
        acts = '0;
        while (done < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                acts = next_acts(acts);
                push_category(acts, (i == len - 1), 1'b0, no_choice);
            end
            done += len;
        end
    endtask

    // one search of len categories: modest scores, a clear winner at the
    // last index in range, and larger scores past the limit that must lose
    task automatic run_long_search(input int len);
        int i;
        logic [S_TDATA_W-1:0] acts;
        acts = '0;
        for (i = 0; i < len; i++) begin
            if (i == CAT_LIMIT - 1)
                acts = {ACT_MOST_POS, ACT_MOST_POS, ACT_MOST_POS, 16'h0000};
            else if (i >= CAT_LIMIT)
                acts = {NUM_CH{ACT_MOST_POS}};
            else
                acts = next_acts(acts) & {NUM_CH{16'hbfff}};
            push_category(acts, (i == len - 1), 1'b0, no_choice);
        end
    endtask

    // directed plan rows
    function automatic plan_row_t cat_row(input int a0, input int a1, input int a2,
                                          input int a3, input bit last);
        plan_row_t r;
        r = '{default: '0};
        r.acts = {16'(a3), 16'(a2), 16'(a1), 16'(a0)};
        r.last = last;
        return r;
    endfunction

    function automatic plan_row_t chk_row(input int a0, input int a1, input int a2,
                                          input int a3, input int idx, input longint score);
        plan_row_t r;
        r = cat_row(a0, a1, a2, a3, 1'b1);
        r.typed      = 1'b1;
        r.want.idx   = 10'(idx);
        r.want.score = score[SCORE_W-1:0];
        r.want.ovf   = 1'b0;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // main sequence
    initial begin
        plan_row_t plan [$];
        int        src_pct  [4];
        int        sink_pct [4];
        int        ph;
        int        r;

        src_pct  = '{0, 51, 0, 15};
        sink_pct = '{0, 0, 51, 15};
        no_choice = '{default: '0};
        for (r = 0; r < NUM_CH; r++) gain_reg[r] = GAIN_RESET;
        skip_reg   = '0;
        cat_count  = 0;
        lead_idx   = '0;
        lead_score = 0;
        lead_valid = 1'b0;
        ovf_seen   = 1'b0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        n_errors = 0;
        n_results = 0;
        n_ovf_results = 0;
        n_cats_sent = 0;
        n_searches = 0;
        n_cfg = 0;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gains: zero, both extremes, ties, a negative first category
        plan.push_back(chk_row(0, 0, 0, 0, 0, 0));
        plan.push_back(chk_row(32767, 32767, 32767, 32767, 0, 2147418112));
        plan.push_back(chk_row(-32768, -32768, -32768, -32768, 0, -64'sd2147483648));
        plan.push_back(cat_row(1, 0, 0, 0, 1'b0));
        plan.push_back(cat_row(5, 0, 0, 0, 1'b0));
        plan.push_back(chk_row(5, 0, 0, 0, 1, 81920));
        plan.push_back(cat_row(-1, 0, 0, 0, 1'b0));
        plan.push_back(chk_row(-2, 0, 0, 0, 0, -16384));
        // full-scale gains: score extremes
        plan.push_back(cfg_row(REG_GAIN_CH0, 16'hffff));
        plan.push_back(cfg_row(REG_GAIN_CH1, 16'hffff));
        plan.push_back(cfg_row(REG_GAIN_CH2, 16'hffff));
        plan.push_back(cfg_row(REG_GAIN_CH3, 16'hffff));
        plan.push_back(cfg_row(REG_CHANNEL_SKIP, 16'h0000));
        plan.push_back(chk_row(32767, 32767, 32767, 32767, 0, 64'sd8589541380));
        plan.push_back(chk_row(-32768, -32768, -32768, -32768, 0, -64'sd8589803520));
        plan.push_back(cat_row(32767, -32768, 1, -1, 1'b0));
        plan.push_back(cat_row(-32768, 32767, -1, 1, 1'b0));
        plan.push_back(cat_row(100, 200, 300, 400, 1'b1));
        // mixed gains, two lanes skipped, a write past the register list
        plan.push_back(cfg_row(REG_GAIN_CH0, 16'h0000));
        plan.push_back(cfg_row(REG_GAIN_CH2, 16'h0001));
        plan.push_back(cfg_row(REG_GAIN_CH3, GAIN_RESET));
        plan.push_back(cfg_row(REG_CHANNEL_SKIP, 16'h0005));
        plan.push_back(cfg_row(REG_SPARE_LAST, 16'hffff));
        plan.push_back(cat_row(32767, -5, 32767, 7, 1'b0));
        plan.push_back(cat_row(-32768, 3, -32768, 9, 1'b0));
        plan.push_back(cat_row(0, 3, 0, 9, 1'b1));
        // every lane skipped: all scores zero, first category wins
        plan.push_back(cfg_row(REG_CHANNEL_SKIP, 16'h000f));
        plan.push_back(cat_row(32767, 32767, 32767, 32767, 1'b0));
        plan.push_back(cat_row(-32768, -32768, -32768, -32768, 1'b0));
        plan.push_back(chk_row(123, -456, 789, -1000, 0, 0));
        // back to reset gains, tie across lanes
        plan.push_back(cfg_row(REG_GAIN_CH0, GAIN_RESET));
        plan.push_back(cfg_row(REG_GAIN_CH1, GAIN_RESET));
        plan.push_back(cfg_row(REG_GAIN_CH2, GAIN_RESET));
        plan.push_back(cfg_row(REG_CHANNEL_SKIP, 16'h0000));
        plan.push_back(cfg_row(REG_SPARE_FIRST, 16'h0000));
        plan.push_back(cat_row(0, 0, 0, 1, 1'b0));
        plan.push_back(chk_row(0, 0, 1, 0, 0, 16384));

        // walk the directed plan; writes only once the block is idle
        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].is_cfg) begin
                if (r == 0 || !plan[r-1].is_cfg) wait_idle(DRAIN_CYCLES);
                write_reg(plan[r].reg_idx, plan[r].reg_val);
                if (r == plan.size() - 1 || !plan[r+1].is_cfg) cfg_valid <= 1'b0;
            end else begin
                push_category(plan[r].acts, plan[r].last, plan[r].typed, plan[r].want);
            end
        end

        // random searches under each idle pattern, two settings apiece
        for (ph = 0; ph < 4; ph++) begin
            src_gap_pct    = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            repeat (2) begin
                set_random_config(1'b0);
                run_searches(5);
            end
        end

        // receiver holds off while short searches pile up
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        run_searches(8);

        // a search through the full index range and past the category limit
        src_gap_pct    = 15;
        sink_stall_pct = 15;
        set_random_config(1'b1);
        run_long_search(CAT_LIMIT + 2);
        run_searches(4);

        wait_idle(20);
        $display("covered %0d searches over %0d categories, %0d results checked (%0d flagged",
                 n_searches, n_cats_sent, n_results, n_ovf_results);
        $display("  overflow), %0d register writes, idle and hold-off receiver phases",
                 n_cfg);
        if (n_errors == 0) begin
            $display("tb_weighted_channel_argmax: PASS");
        end else begin
            $display("tb_weighted_channel_argmax: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

### weighted_channel_argmax.f
rtl/wca_pkg.sv
rtl/wca_lane.sv
rtl/wca_merge.sv
rtl/weighted_channel_argmax.sv
tb/tb_weighted_channel_argmax.sv
